/* hw/rtl/stick_gesture_arm_control_defines.svh */
// Assertion macros shared by the stick gesture arm control RTL.
`ifndef STICK_GESTURE_ARM_CONTROL_DEFINES_SVH
`define STICK_GESTURE_ARM_CONTROL_DEFINES_SVH

`ifndef ASSERT_OFF
`define SGAC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define SGAC_ASSERT_ANY(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SGAC_ASSERT(lbl, prop, msg)
`define SGAC_ASSERT_ANY(lbl, prop, msg)
`endif

`endif

/* hw/rtl/sgac_pkg.sv */
// Shared types and constants for the stick gesture arm control block.
package sgac_pkg;

  localparam int NUM_CHANNELS = 4;
  localparam int POS_W        = 12;
  localparam int MIN_POS_W    = 11;
  localparam int COUNT_W      = 4;
  localparam int PATTERN_W    = 64;
  localparam int KINDS_W      = 16;
  localparam int CODE_W       = 2;
  localparam int CMD_SLOTS    = 8;
  localparam int CMD_BITS     = NUM_CHANNELS * CODE_W;
  localparam int CFG_DATA_W   = 64;
  localparam int CFG_IDX_W    = 2;

  localparam logic [MIN_POS_W-1:0] MIN_POS_RESET = MIN_POS_W'(1638);

  localparam logic [CODE_W-1:0] PAT_IGNORE = 2'd0;
  localparam logic [CODE_W-1:0] PAT_POS    = 2'd1;
  localparam logic [CODE_W-1:0] PAT_NEG    = 2'd2;

  localparam logic [CODE_W-1:0] KIND_ARM    = 2'd0;
  localparam logic [CODE_W-1:0] KIND_DISARM = 2'd1;
  localparam logic [CODE_W-1:0] KIND_TOGGLE = 2'd2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MIN_POSITION     = 2'd0,
    REG_COMMAND_COUNT    = 2'd1,
    REG_COMMAND_PATTERNS = 2'd2,
    REG_COMMAND_KINDS    = 2'd3
  } cfg_reg_t;

  typedef logic signed [POS_W-1:0] pos_t;

  typedef struct packed {
    pos_t chan0_pos;
    pos_t chan1_pos;
    pos_t chan2_pos;
    pos_t chan3_pos;
  } in_item_t;

  typedef struct packed {
    logic                 armed_flag;
    logic [CMD_SLOTS-1:0] fired_mask;
    logic                 arm_changed;
  } out_item_t;

endpackage

/* hw/rtl/sgac_in_if.sv */
// Input channel carrying one set of four stick positions per item.
interface sgac_in_if;
  import sgac_pkg::*;

  logic valid;
  logic ready;
  pos_t chan0_pos;
  pos_t chan1_pos;
  pos_t chan2_pos;
  pos_t chan3_pos;

  modport source (output valid, output chan0_pos, output chan1_pos,
                  output chan2_pos, output chan3_pos, input ready);
  modport sink   (input valid, input chan0_pos, input chan1_pos,
                  input chan2_pos, input chan3_pos, output ready);
endinterface

/* hw/rtl/sgac_out_if.sv */
// Result channel carrying the arm state and fired commands per item.
interface sgac_out_if;
  import sgac_pkg::*;

  logic                 valid;
  logic                 ready;
  logic                 armed_flag;
  logic [CMD_SLOTS-1:0] fired_mask;
  logic                 arm_changed;

  modport source (output valid, output armed_flag, output fired_mask,
                  output arm_changed, input ready);
  modport sink   (input valid, input armed_flag, input fired_mask,
                  input arm_changed, output ready);
endinterface

/* hw/rtl/stick_gesture_arm_control.sv */
// Stick gesture arm control: one item is accepted per cycle when the result side
// takes its items. The item is captured in an input register; from there all
// commands are matched in parallel and the ordered arm/disarm/toggle chain across
// the commands resolves in one pass into the result register, which also updates
// the per-command edge state and the armed flag. Configuration writes take effect
// at once.
`include "stick_gesture_arm_control_defines.svh"

module stick_gesture_arm_control #(
  parameter int MAX_COMMANDS = 8
) (
  input  logic                           clk,
  input  logic                           rst_n,
  sgac_in_if.sink                        in_ch,
  sgac_out_if.source                     out_ch,
  input  logic                           cfg_we,
  input  logic [sgac_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [sgac_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import sgac_pkg::*;

  logic [MIN_POS_W-1:0] min_position_r;
  logic [COUNT_W-1:0]   command_count_r;
  logic [PATTERN_W-1:0] command_patterns_r;
  logic [KINDS_W-1:0]   command_kinds_r;

  logic     s1_valid_r;
  in_item_t s1_item_r;
  logic     out_valid_r;
  out_item_t out_item_r;

  logic [MAX_COMMANDS-1:0] active_r;
  logic [MAX_COMMANDS-1:0] active_nxt;
  logic                    armed_r;
  logic                    armed_nxt;
  logic [CMD_SLOTS-1:0]    fired_nxt;

  logic advance;
  logic in_take;
  logic load_result;

  pos_t                 pos     [NUM_CHANNELS];
  logic [POS_W-1:0]     mag     [NUM_CHANNELS];
  logic [MAX_COMMANDS-1:0] match;
  logic [COUNT_W-1:0]   eff_count;

  assign advance     = !out_valid_r || out_ch.ready;
  assign in_ch.ready = !s1_valid_r || advance;
  assign in_take     = in_ch.valid && in_ch.ready;
  assign load_result = advance && s1_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_position_r     <= MIN_POS_RESET;
      command_count_r    <= '0;
      command_patterns_r <= '0;
      command_kinds_r    <= '0;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_MIN_POSITION:     min_position_r     <= cfg_wdata[MIN_POS_W-1:0];
        REG_COMMAND_COUNT:    command_count_r    <= cfg_wdata[COUNT_W-1:0];
        REG_COMMAND_PATTERNS: command_patterns_r <= cfg_wdata[PATTERN_W-1:0];
        REG_COMMAND_KINDS:    command_kinds_r    <= cfg_wdata[KINDS_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_item_r.chan0_pos <= in_ch.chan0_pos;
      s1_item_r.chan1_pos <= in_ch.chan1_pos;
      s1_item_r.chan2_pos <= in_ch.chan2_pos;
      s1_item_r.chan3_pos <= in_ch.chan3_pos;
    end
  end

  assign pos[0] = s1_item_r.chan0_pos;
  assign pos[1] = s1_item_r.chan1_pos;
  assign pos[2] = s1_item_r.chan2_pos;
  assign pos[3] = s1_item_r.chan3_pos;

  always_comb begin
    for (int c = 0; c < NUM_CHANNELS; c++) begin
      mag[c] = pos[c][POS_W-1] ? (~pos[c] + 1'b1) : pos[c];
    end
  end

  always_comb begin
    logic [CODE_W-1:0] code;
    logic              deflected;
    for (int k = 0; k < MAX_COMMANDS; k++) begin
      match[k] = 1'b1;
      for (int c = 0; c < NUM_CHANNELS; c++) begin
        code      = command_patterns_r[k*CMD_BITS + c*CODE_W +: CODE_W];
        deflected = mag[c] >= {1'b0, min_position_r};
        if (code == PAT_POS) begin
          if (!deflected || pos[c][POS_W-1]) begin
            match[k] = 1'b0;
          end
        end else if (code == PAT_NEG) begin
          if (!deflected || (!pos[c][POS_W-1] && pos[c] != '0)) begin
            match[k] = 1'b0;
          end
        end
      end
    end
  end

  assign eff_count = (command_count_r > COUNT_W'(MAX_COMMANDS)) ?
                     COUNT_W'(MAX_COMMANDS) : command_count_r;

  always_comb begin
    logic [CODE_W-1:0] kind;
    active_nxt = active_r;
    armed_nxt  = armed_r;
    fired_nxt  = '0;
    for (int k = 0; k < MAX_COMMANDS; k++) begin
      kind = command_kinds_r[k*CODE_W +: CODE_W];
      if (COUNT_W'(k) < eff_count) begin
        if (match[k]) begin
          if (!active_r[k]) begin
            fired_nxt[k]  = 1'b1;
            active_nxt[k] = 1'b1;
            case (kind)
              KIND_ARM:    armed_nxt = 1'b1;
              KIND_DISARM: armed_nxt = 1'b0;
              KIND_TOGGLE: armed_nxt = !armed_nxt;
              default:     ;
            endcase
          end
        end else begin
          active_nxt[k] = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r    <= '0;
      armed_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= s1_valid_r;
      if (s1_valid_r) begin
        active_r <= active_nxt;
        armed_r  <= armed_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_result) begin
      out_item_r.armed_flag  <= armed_nxt;
      out_item_r.fired_mask  <= fired_nxt;
      out_item_r.arm_changed <= armed_nxt != armed_r;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.armed_flag  = out_item_r.armed_flag;
  assign out_ch.fired_mask  = out_item_r.fired_mask;
  assign out_ch.arm_changed = out_item_r.arm_changed;

  `SGAC_ASSERT(a_armed_tracks_result, out_valid_r |-> (out_item_r.armed_flag == armed_r), "Result arm state differs from the held arm state.")
  `SGAC_ASSERT(a_change_needs_fire, (out_valid_r && out_item_r.arm_changed) |-> (out_item_r.fired_mask != '0), "Arm state changed with no command fired.")
  `SGAC_ASSERT(a_fired_is_active, out_valid_r |-> ((out_item_r.fired_mask[MAX_COMMANDS-1:0] & ~active_r) == '0), "A fired command is not marked active.")
  `SGAC_ASSERT(a_stall_blocks_input, (s1_valid_r && out_valid_r && !out_ch.ready) |-> !in_ch.ready, "Input taken while both stages are stalled.")

endmodule
